// ===== design/hhc_pkg.sv =====
`default_nettype none
package hhc_pkg;
	localparam int MAX_CLUSTERS_DEF = 16;
	localparam int HITS_PER_CLUSTER_DEF = 8;
	localparam int TW = 16;
	localparam int EW = 20;
	localparam int DLIM_RESET = 10000;
	localparam int TWIN_RESET = 80;
	localparam logic [EW-1:0] ENERGY_MAX = 20'hFFFFF;
	localparam logic REG_DLIM = 1'b0;
	localparam logic REG_TWIN = 1'b1;

	typedef struct packed {
		logic signed [15:0] z;
		logic signed [15:0] y;
		logic signed [15:0] x;
	} pos_t;

	typedef struct packed {
		pos_t p;
		logic [15:0] e;
		logic signed [15:0] t;
	} hit_t;

	typedef struct packed {
		logic join_ok;
		logic full;
	} cell_res_t;
endpackage
`default_nettype wire

// ===== design/hhc_cell.sv =====
`default_nettype none
module hhc_cell #(
	parameter int HPC = hhc_pkg::HITS_PER_CLUSTER_DEF,
	parameter int CW = $clog2(HPC + 1)
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic clear,
	input  wire logic open,
	input  wire logic start,
	input  wire logic commit,
	input  wire logic [CW-1:0] step,
	input  wire hhc_pkg::hit_t hit,
	input  wire logic [31:0] dlim,
	input  wire logic [15:0] twin,
	output hhc_pkg::cell_res_t res,
	output logic signed [23:0] tsum,
	output logic [hhc_pkg::EW-1:0] esum,
	output logic [CW-1:0] cnt
);
	localparam int KW = (HPC > 1) ? $clog2(HPC) : 1;
	logic active_q;
	logic [CW-1:0] cnt_q;
	logic signed [23:0] tsum_q;
	logic [hhc_pkg::EW-1:0] esum_q;
	hhc_pkg::pos_t pos_q [HPC];
	logic near_q, tok_q;
	logic signed [17:0] dx, dy, dz;
	logic [35:0] sx, sy, sz;
	logic [37:0] d2;
	logic signed [40:0] prod, diff, adiff;
	logic [40:0] lim;
	logic [20:0] esum_w;
	hhc_pkg::pos_t q;
	logic [KW-1:0] k;

	assign k = step[KW-1:0];
	assign q = pos_q[k];
	assign dx = 18'(q.x) - 18'(hit.p.x);
	assign dy = 18'(q.y) - 18'(hit.p.y);
	assign dz = 18'(q.z) - 18'(hit.p.z);
	assign sx = 36'(dx * dx);
	assign sy = 36'(dy * dy);
	assign sz = 36'(dz * dz);
	assign d2 = 38'(sx) + 38'(sy) + 38'(sz);
	assign prod = 41'($signed({1'b0, cnt_q})) * 41'(hit.t);
	assign diff = 41'(tsum_q) - prod;
	assign adiff = diff[40] ? -diff : diff;
	assign lim = 41'(twin) * 41'(cnt_q);
	assign esum_w = 21'(esum_q) + 21'(hit.e);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			near_q <= 1'b0;
			tok_q <= 1'b0;
		end else begin
			if (clear) active_q <= 1'b0;
			if (start) begin
				near_q <= 1'b0;
				tok_q <= (cnt_q != '0) && (adiff < $signed(lim));
			end else if (step < cnt_q && d2 < 38'(dlim)) begin
				near_q <= 1'b1;
			end
			if (open) active_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (open) begin
			cnt_q <= CW'(1);
			tsum_q <= 24'(hit.t);
			esum_q <= hhc_pkg::EW'(hit.e);
			pos_q[0] <= hit.p;
		end else if (commit && res.join_ok && !res.full) begin
			pos_q[cnt_q[KW-1:0]] <= hit.p;
			cnt_q <= cnt_q + CW'(1);
			tsum_q <= tsum_q + 24'(hit.t);
			esum_q <= esum_w[20] ? hhc_pkg::ENERGY_MAX : esum_w[19:0];
		end
	end

	assign res.join_ok = active_q && tok_q && near_q;
	assign res.full = (cnt_q >= CW'(HPC));
	assign tsum = tsum_q;
	assign esum = esum_q;
	assign cnt = cnt_q;
endmodule
`default_nettype wire

// ===== design/hhc_div.sv =====
`default_nettype none
module hhc_div (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic go,
	input  wire logic signed [23:0] num,
	input  wire logic [5:0] den,
	output logic busy,
	output logic signed [15:0] quo
);
	logic [4:0] n_q;
	logic [23:0] r_q, a_q;
	logic neg_q;
	logic [24:0] trial;
	logic [23:0] qabs;
	logic [5:0] den_q;
	assign trial = {r_q, a_q[23]} - 25'(den_q);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy <= 1'b0;
			n_q <= '0;
		end else if (go) begin
			busy <= 1'b1;
			n_q <= 5'd24;
		end else if (busy) begin
			n_q <= n_q - 5'd1;
			if (n_q == 5'd1) busy <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (go) begin
			neg_q <= num[23];
			a_q <= num[23] ? 24'(-num) : 24'(num);
			r_q <= '0;
			den_q <= den;
		end else if (busy) begin
			if (!trial[24]) r_q <= trial[23:0];
			else r_q <= {r_q[22:0], a_q[23]};
			a_q <= {a_q[22:0], !trial[24]};
		end
	end
	assign qabs = neg_q ? -a_q : a_q;
	assign quo = qabs[15:0];
endmodule
`default_nettype wire

// ===== design/hodoscope_hit_clustering_core.sv =====
// A hit is taken only in IDLE; no new hit is accepted until the last one reaches the output register.
// The cells scan stored positions one per cycle and the mean time comes from a 24-step
// serial divider.
// The output register frees the datapath while a result waits.
// Reset clears the cluster count and restores both registers to defaults.
`default_nettype none
module hodoscope_hit_clustering_core #(
	parameter int MAX_CLUSTERS = hhc_pkg::MAX_CLUSTERS_DEF,
	parameter int HITS_PER_CLUSTER = hhc_pkg::HITS_PER_CLUSTER_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic s_tready,
	// [0] first_of_event, [16:1] hit_time, [32:17] hit_energy,
	// [48:33] pos_x, [64:49] pos_y, [80:65] pos_z, zero fill to 88
	input  wire logic [87:0] s_tdata,
	output logic m_tvalid,
	input  wire logic m_tready,
	// [15:0] joined_mask, [16] opened_new, [20:17] cluster_index,
	// [36:21] cluster_mean_time, [56:37] cluster_energy, [57] table_full,
	// [58] cluster_full, zero fill to 64
	output logic [63:0] m_tdata,
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic cfg_index,
	input  wire logic [31:0] cfg_data
);
	localparam int CW = $clog2(HITS_PER_CLUSTER + 1);
	localparam int IW = $clog2(MAX_CLUSTERS);
	localparam int NW = $clog2(MAX_CLUSTERS + 1);
	localparam int MB = (MAX_CLUSTERS < 16) ? MAX_CLUSTERS : 16;

	typedef enum logic [2:0] {IDLE, LOAD, SCAN, DECIDE, DIVGO, DIVW, OUTW} st_t;
	st_t st_q;
	logic [31:0] dlim_q;
	logic [15:0] twin_q;
	hhc_pkg::hit_t hit_q;
	logic [NW-1:0] ccnt_q;
	logic [CW-1:0] step_q;
	logic [IW-1:0] first_q;
	logic [15:0] mask_q;
	logic opened_q, tfull_q, cfull_q, any_q;
	logic [63:0] out_q;

	hhc_pkg::cell_res_t res [MAX_CLUSTERS];
	logic signed [23:0] tsum [MAX_CLUSTERS];
	logic [hhc_pkg::EW-1:0] esum [MAX_CLUSTERS];
	logic [CW-1:0] cnt [MAX_CLUSTERS];
	logic [MAX_CLUSTERS-1:0] join_v, full_v, open_v;
	logic clear, commit, div_go, div_busy;
	logic signed [15:0] quo;
	logic [IW-1:0] fidx;
	logic fany;

	assign clear = (st_q == IDLE) && s_tvalid && s_tready && s_tdata[0];
	assign commit = (st_q == DECIDE);

	genvar g;
	generate
		for (g = 0; g < MAX_CLUSTERS; g++) begin : g_cell
			assign join_v[g] = res[g].join_ok && (NW'(g) < ccnt_q);
			assign full_v[g] = res[g].full;
			assign open_v[g] = commit && !fany && (NW'(g) == ccnt_q);
			hhc_cell #(.HPC(HITS_PER_CLUSTER), .CW(CW)) u_cell (
				.clk, .arst_n, .clear(clear && 1'b1), .open(open_v[g]),
				.start(st_q == LOAD), .commit(commit && join_v[g]),
				.step(step_q), .hit(hit_q), .dlim(dlim_q), .twin(twin_q),
				.res(res[g]), .tsum(tsum[g]), .esum(esum[g]), .cnt(cnt[g])
			);
		end
	endgenerate

	always_comb begin
		fidx = '0;
		fany = 1'b0;
		for (int i = MAX_CLUSTERS - 1; i >= 0; i--) begin
			if (join_v[i]) begin
				fidx = IW'(i);
				fany = 1'b1;
			end
		end
	end

	hhc_div u_div (
		.clk, .arst_n, .go(div_go), .num(tsum[first_q]),
		.den(6'(cnt[first_q])), .busy(div_busy), .quo(quo)
	);
	assign div_go = (st_q == DIVGO);

	assign s_tready = (st_q == IDLE);
	assign cfg_ready = 1'b1;
	assign m_tdata = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= IDLE;
			m_tvalid <= 1'b0;
			dlim_q <= 32'(hhc_pkg::DLIM_RESET);
			twin_q <= 16'(hhc_pkg::TWIN_RESET);
			ccnt_q <= '0;
			step_q <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					hhc_pkg::REG_DLIM: dlim_q <= cfg_data;
					hhc_pkg::REG_TWIN: twin_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready && st_q != OUTW) m_tvalid <= 1'b0;
			unique case (st_q)
				IDLE: if (s_tvalid) begin
					hit_q <= s_tdata[80:1];
					if (s_tdata[0]) ccnt_q <= '0;
					st_q <= LOAD;
				end
				LOAD: begin
					step_q <= '0;
					st_q <= SCAN;
				end
				SCAN: begin
					step_q <= step_q + CW'(1);
					if (step_q == CW'(HITS_PER_CLUSTER - 1)) st_q <= DECIDE;
				end
				DECIDE: begin
					mask_q <= 16'(join_v[MB-1:0]);
					cfull_q <= |(join_v & full_v);
					any_q <= fany || (ccnt_q < NW'(MAX_CLUSTERS));
					opened_q <= !fany && (ccnt_q < NW'(MAX_CLUSTERS));
					tfull_q <= !fany && !(ccnt_q < NW'(MAX_CLUSTERS));
					first_q <= fany ? fidx : ccnt_q[IW-1:0];
					if (!fany && ccnt_q < NW'(MAX_CLUSTERS)) ccnt_q <= ccnt_q + NW'(1);
					st_q <= DIVGO;
				end
				DIVGO: st_q <= DIVW;
				DIVW: if (!div_busy) st_q <= OUTW;
				OUTW: if (!m_tvalid || m_tready) begin
					m_tvalid <= 1'b1;
					st_q <= IDLE;
				end
				default: st_q <= IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == OUTW && (!m_tvalid || m_tready)) begin
			out_q <= {5'd0, cfull_q, tfull_q,
				any_q ? esum[first_q] : hhc_pkg::EW'(0),
				any_q ? quo : 16'd0,
				any_q ? 4'(first_q) : 4'd0,
				opened_q, mask_q};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !div_busy) else $error("divider busy while idle");
	assert property (@(posedge clk) disable iff (!arst_n)
		ccnt_q <= NW'(MAX_CLUSTERS)) else $error("cluster count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == DECIDE) |=> !(opened_q && tfull_q)) else $error("open and full");
endmodule
`default_nettype wire

// ===== tb/tb_hodoscope_hit_clustering_core.sv =====
`default_nettype none
module tb_hodoscope_hit_clustering_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NCL = hhc_pkg::MAX_CLUSTERS_DEF;
	localparam int NHIT = hhc_pkg::HITS_PER_CLUSTER_DEF;
	localparam int LATENCY = 1 + NHIT + 3 + 25;
	localparam longint CYCLE_LIMIT = 2000000;

	typedef struct {
		logic first;
		logic signed [15:0] t;
		logic [15:0] e;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} hit_item_t;

	typedef struct {
		logic [15:0] mask;
		logic opened;
		logic [3:0] idx;
		logic signed [15:0] mean;
		logic [hhc_pkg::EW-1:0] energy;
		logic tfull;
		logic cfull;
	} cluster_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [87:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = hhc_pkg::REG_DLIM;
	logic [31:0] cfg_data = '0;

	hodoscope_hit_clustering_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	hit_item_t hit_q[$];
	cluster_res_t cluster_res_q[$];
	bit quiet = 0;
	int mismatches = 0;
	int n_results = 0, n_joined = 0, n_opened = 0, n_tfull = 0, n_cfull = 0, n_multi = 0;
	longint cycles = 0;

	logic [31:0] dist_lim = hhc_pkg::DLIM_RESET;
	logic [15:0] time_win = hhc_pkg::TWIN_RESET;
	int open_clusters = 0;
	longint tsum[NCL];
	logic [hhc_pkg::EW-1:0] esum[NCL];
	int hcnt[NCL];
	logic signed [15:0] px[NCL][NHIT];
	logic signed [15:0] py[NCL][NHIT];
	logic signed [15:0] pz[NCL][NHIT];

	function automatic void store_hit(int c, hit_item_t h);
		logic [31:0] s;
		s = 32'(esum[c]) + 32'(h.e);
		px[c][hcnt[c]] = h.x;
		py[c][hcnt[c]] = h.y;
		pz[c][hcnt[c]] = h.z;
		hcnt[c]++;
		tsum[c] += longint'(h.t);
		esum[c] = (s > 32'(hhc_pkg::ENERGY_MAX)) ? hhc_pkg::ENERGY_MAX
			: s[hhc_pkg::EW-1:0];
	endfunction

	function automatic cluster_res_t cluster_hit(hit_item_t h);
		cluster_res_t r;
		int live, first;
		bit joined, near;
		longint n, diff, dx, dy, dz;
		r = '{default: '0};
		joined = 0;
		first = 0;
		if (h.first)
			open_clusters = 0;
		live = open_clusters;
		for (int c = 0; c < live; c++) begin
			if (hcnt[c] == 0)
				continue;
			n = hcnt[c];
			diff = tsum[c] - n * longint'(h.t);
			if (diff < 0)
				diff = -diff;
			if (!(diff < longint'(time_win) * n))
				continue;
			near = 0;
			for (int k = 0; k < hcnt[c] && k < NHIT; k++) begin
				dx = longint'(px[c][k]) - longint'(h.x);
				dy = longint'(py[c][k]) - longint'(h.y);
				dz = longint'(pz[c][k]) - longint'(h.z);
				if (dx * dx + dy * dy + dz * dz < longint'(dist_lim))
					near = 1;
			end
			if (!near)
				continue;
			if (!joined)
				first = c;
			else if (r.mask != 0)
				n_multi++;
			joined = 1;
			r.mask[c] = 1'b1;
			if (hcnt[c] >= NHIT)
				r.cfull = 1'b1;
			else
				store_hit(c, h);
		end
		if (!joined) begin
			if (open_clusters < NCL) begin
				first = open_clusters;
				hcnt[first] = 0;
				tsum[first] = 0;
				esum[first] = '0;
				store_hit(first, h);
				open_clusters++;
				r.opened = 1'b1;
			end else begin
				r.tfull = 1'b1;
			end
		end
		if (joined || r.opened) begin
			r.idx = first[3:0];
			r.mean = 16'(tsum[first] / longint'(hcnt[first]));
			r.energy = esum[first];
		end
		return r;
	endfunction

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("hodoscope_hit_clustering_core: mismatch");
			$finish;
		end
	end

	// hit driver
	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			cluster_res_q.insert(cluster_res_q.size(), cluster_hit(hit_q.pop_front()));
		if (s_tvalid && !s_tready) begin
			s_tvalid <= 1'b1;
		end else if (hit_q.size() > 0 && arst_n && (quiet || $urandom_range(99) >= 16)) begin
			s_tvalid <= 1'b1;
			s_tdata <= {7'b0, hit_q[0].z, hit_q[0].y, hit_q[0].x, hit_q[0].e,
				hit_q[0].t, hit_q[0].first};
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	// result monitor
	always @(posedge clk) begin
		cluster_res_t want;
		if (m_tvalid && m_tready) begin
			n_results++;
			if (cluster_res_q.size() == 0) begin
				$error("result transfer with no hit pending: %h", m_tdata);
				mismatches++;
			end else begin
				want = cluster_res_q.pop_front();
				if (want.mask != 0) n_joined++;
				if (want.opened) n_opened++;
				if (want.tfull) n_tfull++;
				if (want.cfull) n_cfull++;
				if (m_tdata[15:0] !== want.mask) begin
					$error("joined_mask: expected %h, got %h", want.mask, m_tdata[15:0]);
					mismatches++;
				end
				if (m_tdata[16] !== want.opened) begin
					$error("opened_new: expected %b, got %b", want.opened, m_tdata[16]);
					mismatches++;
				end
				if (m_tdata[20:17] !== want.idx) begin
					$error("cluster_index: expected %0d, got %0d", want.idx, m_tdata[20:17]);
					mismatches++;
				end
				if (m_tdata[36:21] !== want.mean) begin
					$error("cluster_mean_time: expected %0d, got %0d", want.mean,
						$signed(m_tdata[36:21]));
					mismatches++;
				end
				if (m_tdata[56:37] !== want.energy) begin
					$error("cluster_energy: expected %0d, got %0d", want.energy,
						m_tdata[56:37]);
					mismatches++;
				end
				if (m_tdata[57] !== want.tfull) begin
					$error("table_full: expected %b, got %b", want.tfull, m_tdata[57]);
					mismatches++;
				end
				if (m_tdata[58] !== want.cfull) begin
					$error("cluster_full: expected %b, got %b", want.cfull, m_tdata[58]);
					mismatches++;
				end
				if (m_tdata[63:59] !== '0) begin
					$error("fill: expected 0, got %h", m_tdata[63:59]);
					mismatches++;
				end
			end
		end
		m_tready <= arst_n && (quiet || $urandom_range(99) >= 16);
	end

	task automatic write_reg(logic idx, logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == hhc_pkg::REG_DLIM)
			dist_lim = val;
		else
			time_win = val[15:0];
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (hit_q.size() > 0 || cluster_res_q.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic void push_hit(bit f, int t, int e, int x, int y, int z);
		hit_item_t h;
		h.first = f;
		h.t = t[15:0];
		h.e = e[15:0];
		h.x = x[15:0];
		h.y = y[15:0];
		h.z = z[15:0];
		hit_q.insert(hit_q.size(), h);
	endfunction

	function automatic int jitter(int s);
		return int'($urandom_range(2 * s)) - s;
	endfunction

	// one event: hits scattered around a few track centers, with some noise
	function automatic int push_event(int n);
		int nc, sp, tsp;
		int cx[4], cy[4], cz[4], ct[4];
		int c;
		nc = $urandom_range(1, 4);
		sp = $urandom_range(0, 3) == 0 ? 200 : 40;
		tsp = $urandom_range(0, 3) == 0 ? 200 : 30;
		for (int i = 0; i < nc; i++) begin
			cx[i] = jitter(30000);
			cy[i] = jitter(30000);
			cz[i] = jitter(30000);
			ct[i] = jitter(30000);
		end
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 12) begin
				push_hit(i == 0 || $urandom_range(19) == 0, $urandom, $urandom,
					$urandom, $urandom, $urandom);
			end else begin
				c = $urandom_range(nc - 1);
				push_hit(i == 0, ct[c] + jitter(tsp), $urandom_range(65535),
					cx[c] + jitter(sp), cy[c] + jitter(sp), cz[c] + jitter(sp));
			end
		end
		return n;
	endfunction

	task automatic random_hits(int total);
		int done;
		done = 0;
		while (done < total)
			done += push_event($urandom_range(0, 4) == 0 ? $urandom_range(17, 30)
				: $urandom_range(1, 12));
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// extremes, window edge, double join
		push_hit(1, -32768, 0, -32768, -32768, -32768);
		push_hit(0, 32767, 65535, 32767, 32767, 32767);
		push_hit(1, 0, 100, 0, 0, 0);
		push_hit(0, 79, 200, 10, 0, 0);
		push_hit(0, 200, 300, 0, 0, 0);
		push_hit(1, 0, 65535, 0, 0, 0);
		push_hit(0, 0, 65535, 150, 0, 0);
		push_hit(0, 0, 65535, 75, 0, 0);
		push_hit(1, 0, 5, 0, 0, 0);
		push_hit(1, -5, 6, 3, 4, 5);
		// full cluster: ten hits on one spot
		for (int i = 0; i < 10; i++)
			push_hit(i == 0, 3 * i, 65535, 1, -1, i);
		drain();
		// full table: hits one meter apart
		for (int i = 0; i < 19; i++)
			push_hit(i == 0, 0, i, 1000 * i - 9000, 0, 0);
		drain();

		write_reg(hhc_pkg::REG_DLIM, hhc_pkg::DLIM_RESET);
		write_reg(hhc_pkg::REG_TWIN, hhc_pkg::TWIN_RESET);
		random_hits(250);
		quiet = 1;
		random_hits(150);
		drain();
		quiet = 0;
		random_hits(150);

		drain();
		write_reg(hhc_pkg::REG_DLIM, 32'h0);
		write_reg(hhc_pkg::REG_TWIN, 16'h0);
		random_hits(100);

		drain();
		write_reg(hhc_pkg::REG_TWIN, 16'hFFFF);
		write_reg(hhc_pkg::REG_DLIM, 32'hFFFF_FFFF);
		random_hits(250);

		drain();
		write_reg(hhc_pkg::REG_DLIM, 400);
		write_reg(hhc_pkg::REG_TWIN, 30);
		random_hits(300);

		drain();
		write_reg(hhc_pkg::REG_DLIM, $urandom_range(1, 60000));
		write_reg(hhc_pkg::REG_TWIN, $urandom_range(1, 400));
		random_hits(400);

		drain();
		$display("%0d hits checked over five register settings: %0d joined, %0d opened,",
			n_results, n_joined, n_opened);
		$display("%0d multi-joins, %0d full-table drops, %0d full-cluster flags",
			n_multi, n_tfull, n_cfull);
		if (mismatches == 0)
			$display("hodoscope_hit_clustering_core: match");
		else
			$display("hodoscope_hit_clustering_core: mismatch");
		$finish;
	end
endmodule
`default_nettype wire
